// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the checker files of the timer event queue.
// Needs clk and rst_n in the scope of each use; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SEVQ_AST_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sevq check failed");

// Next-cycle implication, disabled during reset
`define SEVQ_AST_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sevq check failed");

`endif

// ===== rtl/core/sevq_pkg.sv =====
// Package for the sorted event timer queue: codes, widths and defaults.
// No dependencies; imported by every module of the block.
package sevq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int ID_BITS_DEF     = 16;
  localparam int TIME_BITS_DEF   = 32;
  localparam int MAX_RESULTS     = 16;

  localparam int ACT_W       = 3;
  localparam int DELAY_W     = 24;
  localparam int TID_W       = 16;
  localparam int EID_W       = 16;
  localparam int TL_W        = 25;
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 48;

  localparam logic [DELAY_W-1:0] MS_MAX = 24'hFFFFFF;

  typedef enum logic [ACT_W-1:0] {
    ACT_ADD   = 3'd0,
    ACT_DEL   = 3'd1,
    ACT_TICK  = 3'd2,
    ACT_REARM = 3'd3,
    ACT_QID   = 3'd4,
    ACT_QNEXT = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_FIRED     = 2'd3
  } status_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef enum logic [1:0] {
    ORD_NONE = 2'd0,
    ORD_INS  = 2'd1,
    ORD_REM  = 2'd2
  } ord_op_t;

endpackage

// ===== rtl/core/sevq_alu.sv =====
// Shared time unit: one add/subtract, with due, order and clamp flags on the result.
// Depends on sevq_pkg.
module sevq_alu #(
  parameter int TIME_BITS = sevq_pkg::TIME_BITS_DEF
) (
  input  sevq_pkg::alu_op_t                op,
  input  logic [TIME_BITS-1:0]             a,
  input  logic [TIME_BITS-1:0]             b,
  input  logic [TIME_BITS-1:0]             key_ref,
  output logic [TIME_BITS-1:0]             res,
  output logic                             due,
  output logic                             ref_lt,
  output logic [sevq_pkg::DELAY_W-1:0]     clamp
);
  import sevq_pkg::*;

  localparam int CW = TIME_BITS + DELAY_W;
  localparam logic [TIME_BITS-1:0] TOP = {1'b1, {(TIME_BITS-1){1'b0}}};

  logic [CW-1:0] res_x;

  // Adder/subtractor, shared by due-time updates, the tick and offset computation
  assign res = (op == ALU_ADD) ? (a + b) : (a - b);

  // Offset read as signed: due at zero or below
  assign due    = (res == '0) || res[TIME_BITS-1];
  // Stored key is below this entry's key: the insert point
  assign ref_lt = key_ref < (res ^ TOP);

  // Time left, clamped to 0 .. MS_MAX
  assign res_x = CW'(res);
  always_comb begin
    if (res[TIME_BITS-1]) begin
      clamp = '0;
    end else if (res_x > CW'(MS_MAX)) begin
      clamp = MS_MAX;
    end else begin
      clamp = DELAY_W'(res);
    end
  end

endmodule

// ===== rtl/core/sevq_order.sv =====
// Due-order list of slot numbers with a length count; insert and remove shift one place.
// Depends on sevq_pkg.
module sevq_order #(
  parameter int QUEUE_DEPTH = sevq_pkg::QUEUE_DEPTH_DEF,
  localparam int SLOT_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sevq_pkg::ord_op_t    op,
  input  logic [SLOT_W-1:0]    pos,
  input  logic [SLOT_W-1:0]    slot,
  input  logic [SLOT_W-1:0]    rd_pos,
  output logic [SLOT_W-1:0]    rd_slot,
  output logic [SLOT_W-1:0]    head,
  output logic [CNT_W-1:0]     qlen
);
  import sevq_pkg::*;

  logic [SLOT_W-1:0] order_r [QUEUE_DEPTH];
  logic [CNT_W-1:0]  qlen_r;

  assign rd_slot = order_r[rd_pos];
  assign head    = order_r[0];
  assign qlen    = qlen_r;

  // Length count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qlen_r <= '0;
    end else begin
      case (op)
        ORD_INS: qlen_r <= qlen_r + 1'b1;
        ORD_REM: qlen_r <= qlen_r - 1'b1;
        default: qlen_r <= qlen_r;
      endcase
    end
  end

  // Slot list: shift up behind an insert, down behind a removal
  always_ff @(posedge clk) begin
    case (op)
      ORD_INS: begin
        if (pos == '0) order_r[0] <= slot;
        for (int i = 1; i < QUEUE_DEPTH; i++) begin
          if (SLOT_W'(i) > pos)       order_r[i] <= order_r[i-1];
          else if (SLOT_W'(i) == pos) order_r[i] <= slot;
        end
      end
      ORD_REM: begin
        for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
          if (SLOT_W'(i) >= pos) order_r[i] <= order_r[i+1];
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/core/sorted_event_timer_queue_core.sv =====
// Top level of the sorted event timer queue: sequencer, entry store, output register.
// Depends on sevq_pkg, sevq_alu and sevq_order.
//
//  channel | dir | handshake         | payload
//  in_     | in  | tvalid / tready   | tuser action, tdata delay/mode/id/rearm value
//  out_    | out | tvalid / tready   | tuser status, tdata id/time left, tlast
//
// One item at a time; in_tready is high only while the sequencer is idle.
// Add: free-slot scan over the store, then insert scan along the due list, each
// insert step one pass through the shared time unit. Delete and id query scan the
// list; tick fires due events from the head of the list. A held result stalls the
// sequencer only when it must emit. The entry store needs no clearing pass on reset.
module sorted_event_timer_queue_core #(
  parameter int QUEUE_DEPTH = sevq_pkg::QUEUE_DEPTH_DEF,
  parameter int ID_BITS     = sevq_pkg::ID_BITS_DEF,
  parameter int TIME_BITS   = sevq_pkg::TIME_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [23:0] delay_ms, [24] variable_mode, [40:25] target_id, [64:41] rearm_value
  input  logic [sevq_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [2:0] action
  input  logic [sevq_pkg::ACT_W-1:0]          in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [15:0] event_id, [40:16] time_left_ms
  output logic [sevq_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // [1:0] status
  output logic [1:0]                          out_tuser,
  output logic                                out_tlast
);
  import sevq_pkg::*;

  localparam int SLOT_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int N_W    = $clog2(MAX_RESULTS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_FREE, S_ADD_DUE, S_KEY, S_INS, S_FIND, S_CLAMP,
    S_TICK, S_FIRE, S_PSCAN, S_RADD, S_EMIT
  } state_t;

  state_t                state_r, ret_r;
  action_t               act_r;
  logic [DELAY_W-1:0]    delay_r, rv_r;
  logic                  varm_r;
  logic [TID_W-1:0]      tid_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [SLOT_W-1:0]     slot_r;
  logic [TIME_BITS-1:0]  key_r, now_r;
  logic [ID_BITS-1:0]    next_id_r, hold_id_r;
  logic [N_W-1:0]        nfire_r;
  logic                  hold_v_r;
  status_t               res_status_r;
  logic [EID_W-1:0]      res_id_r;
  logic [TL_W-1:0]       res_tl_r;
  logic                  res_last_r;
  logic                  out_valid_r, out_last_r;
  status_t               out_status_r;
  logic [EID_W-1:0]      out_id_r;
  logic [TL_W-1:0]       out_tl_r;

  // Entry store
  logic [TIME_BITS-1:0]  due_r [QUEUE_DEPTH];
  logic [ID_BITS-1:0]    id_r  [QUEUE_DEPTH];
  logic [DELAY_W-1:0]    per_r [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] var_r, valid_r, pend_r;

  // Shared unit and list hookup
  alu_op_t               alu_op;
  logic [TIME_BITS-1:0]  alu_a, alu_b, alu_res;
  logic                  alu_due, alu_ref_lt;
  logic [DELAY_W-1:0]    alu_clamp;
  ord_op_t               ord_op;
  logic [SLOT_W-1:0]     ord_pos, ord_rd_slot, ord_head;
  logic [CNT_W-1:0]      ord_qlen;

  logic [SLOT_W-1:0]     sel_slot;
  logic [TIME_BITS-1:0]  sel_due;
  logic [ID_BITS-1:0]    sel_id;
  logic                  id_hit, scan_end, fire, out_free;

  sevq_alu #(.TIME_BITS(TIME_BITS)) u_alu (
    .op(alu_op), .a(alu_a), .b(alu_b), .key_ref(key_r),
    .res(alu_res), .due(alu_due), .ref_lt(alu_ref_lt), .clamp(alu_clamp)
  );

  sevq_order #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_order (
    .clk(clk), .rst_n(rst_n), .op(ord_op), .pos(ord_pos), .slot(slot_r),
    .rd_pos(cnt_r[SLOT_W-1:0]), .rd_slot(ord_rd_slot), .head(ord_head), .qlen(ord_qlen)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_tl_r, out_id_r};
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;
  assign out_free   = !out_valid_r || out_tready;

  // Entry read port: one slot per cycle, picked by state
  always_comb begin
    case (state_r)
      S_INS, S_FIND:   sel_slot = ord_rd_slot;
      S_FIRE:          sel_slot = ord_head;
      S_FREE, S_PSCAN: sel_slot = cnt_r[SLOT_W-1:0];
      default:         sel_slot = slot_r;
    endcase
  end
  assign sel_due  = due_r[sel_slot];
  assign sel_id   = id_r[sel_slot];
  assign id_hit   = (32'(sel_id) == 32'(tid_r));
  assign scan_end = (cnt_r == ord_qlen);
  assign fire     = (ord_qlen != '0) && (nfire_r < N_W'(MAX_RESULTS)) && alu_due;

  // Shared unit operands
  always_comb begin
    case (state_r)
      S_ADD_DUE: begin
        alu_op = ALU_ADD; alu_a = now_r; alu_b = TIME_BITS'(delay_r);
      end
      S_RADD: begin
        alu_op = ALU_ADD; alu_a = sel_due;
        alu_b  = var_r[slot_r] ? TIME_BITS'(rv_r) : TIME_BITS'(per_r[slot_r]);
      end
      S_TICK: begin
        alu_op = ALU_ADD; alu_a = now_r; alu_b = TIME_BITS'(1);
      end
      default: begin
        alu_op = ALU_SUB; alu_a = sel_due; alu_b = now_r;
      end
    endcase
  end

  // List operations
  always_comb begin
    ord_op  = ORD_NONE;
    ord_pos = cnt_r[SLOT_W-1:0];
    case (state_r)
      S_INS:  if (scan_end || alu_ref_lt) ord_op = ORD_INS;
      S_FIND: if (!scan_end && id_hit && act_r == ACT_DEL) ord_op = ORD_REM;
      S_FIRE: begin
        ord_pos = '0;
        if (fire) ord_op = ORD_REM;
      end
      default: ord_op = ORD_NONE;
    endcase
  end

  // Sequencer, flags and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      now_r       <= '0;
      next_id_r   <= ID_BITS'(1);
      valid_r     <= '0;
      pend_r      <= '0;
      out_valid_r <= 1'b0;
      hold_v_r    <= 1'b0;
      nfire_r     <= '0;
    end else begin
      if (out_valid_r && out_tready && state_r != S_EMIT) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: if (in_tvalid) begin
          act_r        <= action_t'(in_tuser);
          delay_r      <= in_tdata[23:0];
          varm_r       <= in_tdata[24];
          tid_r        <= in_tdata[40:25];
          rv_r         <= in_tdata[64:41];
          cnt_r        <= '0;
          res_status_r <= ST_OK;
          res_id_r     <= '0;
          res_tl_r     <= '0;
          res_last_r   <= 1'b1;
          ret_r        <= S_IDLE;
          slot_r       <= ord_head;
          case (action_t'(in_tuser))
            ACT_ADD:   state_r <= S_FREE;
            ACT_DEL:   state_r <= S_FIND;
            ACT_QID:   state_r <= S_FIND;
            ACT_TICK:  state_r <= S_TICK;
            ACT_REARM: state_r <= S_PSCAN;
            ACT_QNEXT: begin
              if (ord_qlen == '0) begin
                res_tl_r <= '1;
                state_r  <= S_EMIT;
              end else begin
                state_r  <= S_CLAMP;
              end
            end
            default:   state_r <= S_EMIT;
          endcase
        end
        // First free slot
        S_FREE: begin
          if (cnt_r == CNT_W'(QUEUE_DEPTH)) begin
            res_status_r <= ST_FULL;
            state_r      <= S_EMIT;
          end else if (!valid_r[sel_slot]) begin
            slot_r  <= sel_slot;
            state_r <= S_ADD_DUE;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_ADD_DUE: begin
          valid_r[slot_r] <= 1'b1;
          pend_r[slot_r]  <= 1'b0;
          res_id_r        <= EID_W'(next_id_r);
          next_id_r       <= next_id_r + 1'b1;
          state_r         <= S_KEY;
        end
        // Order key of the entry being queued
        S_KEY: begin
          key_r   <= alu_res ^ {1'b1, {(TIME_BITS-1){1'b0}}};
          cnt_r   <= '0;
          state_r <= S_INS;
        end
        S_INS: begin
          if (scan_end || alu_ref_lt) state_r <= S_EMIT;
          else                        cnt_r   <= cnt_r + 1'b1;
        end
        // Id search in list order
        S_FIND: begin
          if (scan_end) begin
            res_status_r <= ST_NOT_FOUND;
            res_id_r     <= tid_r;
            if (act_r == ACT_QID) res_tl_r <= '1;
            state_r      <= S_EMIT;
          end else if (id_hit) begin
            res_id_r <= EID_W'(sel_id);
            slot_r   <= sel_slot;
            if (act_r == ACT_DEL) begin
              valid_r[sel_slot] <= 1'b0;
              state_r           <= S_EMIT;
            end else begin
              state_r <= S_CLAMP;
            end
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_CLAMP: begin
          res_tl_r <= TL_W'(alu_clamp);
          state_r  <= S_EMIT;
        end
        S_TICK: begin
          now_r    <= alu_res;
          nfire_r  <= '0;
          hold_v_r <= 1'b0;
          state_r  <= S_FIRE;
        end
        // Fire the head while due, up to MAX_RESULTS per tick; one result is held back to mark the last
        S_FIRE: begin
          if (fire) begin
            pend_r[sel_slot] <= 1'b1;
            nfire_r          <= nfire_r + 1'b1;
            hold_id_r        <= sel_id;
            hold_v_r         <= 1'b1;
            if (hold_v_r) begin
              res_status_r <= ST_FIRED;
              res_id_r     <= EID_W'(hold_id_r);
              res_last_r   <= 1'b0;
              ret_r        <= S_FIRE;
              state_r      <= S_EMIT;
            end
          end else begin
            if (hold_v_r) begin
              res_status_r <= ST_FIRED;
              res_id_r     <= EID_W'(hold_id_r);
            end
            res_last_r <= 1'b1;
            ret_r      <= S_IDLE;
            state_r    <= S_EMIT;
          end
        end
        // Lowest-numbered pending entry with the id
        S_PSCAN: begin
          if (cnt_r == CNT_W'(QUEUE_DEPTH)) begin
            res_status_r <= ST_NOT_FOUND;
            res_id_r     <= tid_r;
            state_r      <= S_EMIT;
          end else if (valid_r[sel_slot] && pend_r[sel_slot] && id_hit) begin
            slot_r   <= sel_slot;
            res_id_r <= EID_W'(sel_id);
            if (rv_r == '0) begin
              valid_r[sel_slot] <= 1'b0;
              pend_r[sel_slot]  <= 1'b0;
              state_r           <= S_EMIT;
            end else begin
              state_r <= S_RADD;
            end
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_RADD: begin
          pend_r[slot_r] <= 1'b0;
          state_r        <= S_KEY;
        end
        S_EMIT: if (out_free) begin
          out_valid_r  <= 1'b1;
          out_status_r <= res_status_r;
          out_id_r     <= res_id_r;
          out_tl_r     <= res_tl_r;
          out_last_r   <= res_last_r;
          state_r      <= ret_r;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Entry payload writes
  always_ff @(posedge clk) begin
    case (state_r)
      S_ADD_DUE: begin
        due_r[slot_r] <= alu_res;
        id_r[slot_r]  <= next_id_r;
        per_r[slot_r] <= delay_r;
        var_r[slot_r] <= varm_r;
      end
      S_RADD:  due_r[slot_r] <= alu_res;
      default: ;
    endcase
  end

endmodule

// ===== rtl/core/sevq_checker.sv =====
// Port-level checks for the sorted event timer queue, bound to the top level.
// Depends on sevq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sevq_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_tvalid,
  input logic                                in_tready,
  input logic [sevq_pkg::IN_TDATA_W-1:0]     in_tdata,
  input logic [sevq_pkg::ACT_W-1:0]          in_tuser,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [sevq_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input logic [1:0]                          out_tuser,
  input logic                                out_tlast
);
  import sevq_pkg::*;

  // A stalled result stays
  `SEVQ_AST_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid)
  `SEVQ_AST_NEXT(a_out_stable, out_tvalid && !out_tready, $stable(out_tdata) && $stable(out_tlast))
  // One item at a time: busy right after an accept
  `SEVQ_AST_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready)
  // Only fired events can be followed by more results
  `SEVQ_AST_SAME(a_last_non_fire, out_tvalid && (out_tuser != ST_FIRED), out_tlast)

endmodule

bind sorted_event_timer_queue_core sevq_checker u_sevq_checker (.*);

// ===== tb/sorted_event_timer_queue_core_chk.sv =====
// Checker for the sorted event timer queue: watches both channels, predicts results.
// Depends on sevq_pkg; instantiated beside the block by sorted_event_timer_queue_core_tb.
`timescale 1ns / 100ps

module sorted_event_timer_queue_core_chk
  import sevq_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic [ACT_W-1:0]       in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic [1:0]             out_tuser,
  input  logic                   out_tlast,
  output int                     fail_count,
  output int                     awaiting,
  output int                     checked,
  output int                     fired_seen
);

  localparam int DEPTH = QUEUE_DEPTH_DEF;

  typedef struct packed {
    status_t          st;
    logic [EID_W-1:0] id;
    logic [TL_W-1:0]  tl;
    logic             last;
  } timer_result_t;

  // shadow of the event store
  logic [31:0]        now_ms;
  logic [EID_W-1:0]   next_id;
  logic [31:0]        due_at   [DEPTH];
  logic [EID_W-1:0]   ev_id    [DEPTH];
  logic [DELAY_W-1:0] period   [DEPTH];
  logic               var_mode [DEPTH];
  logic               in_use   [DEPTH];
  logic               fired    [DEPTH];
  int                 due_list [DEPTH];
  int                 due_len;

  timer_result_t pending_results[$];

  assign awaiting = pending_results.size();

  function automatic logic [31:0] offset_of(int s);
    return due_at[s] - now_ms;
  endfunction

  // due when the signed offset is zero or negative
  function automatic bit is_due(int s);
    logic [31:0] d;
    d = offset_of(s);
    return (d == 0) || d[31];
  endfunction

  function automatic logic [TL_W-1:0] time_left(int s);
    logic [31:0] d;
    d = offset_of(s);
    if (d[31]) return '0;
    if (d > {8'h0, MS_MAX}) return {1'b0, MS_MAX};
    return {1'b0, d[23:0]};
  endfunction

  function automatic int find_queued(logic [EID_W-1:0] id);
    for (int i = 0; i < due_len; i++)
      if (ev_id[due_list[i]] == id) return i;
    return -1;
  endfunction

  // keep the due list sorted by signed offset; ties go behind equals
  task automatic enqueue(int s);
    int pos;
    pos = 0;
    while (pos < due_len &&
           !((offset_of(s) ^ 32'h8000_0000) < (offset_of(due_list[pos]) ^ 32'h8000_0000)))
      pos++;
    for (int i = due_len; i > pos; i--) due_list[i] = due_list[i-1];
    due_list[pos] = s;
    due_len++;
  endtask

  task automatic dequeue(int pos);
    for (int i = pos; i + 1 < due_len; i++) due_list[i] = due_list[i+1];
    due_len--;
  endtask

  task automatic expect_result(status_t st, logic [EID_W-1:0] id, logic [TL_W-1:0] tl,
                               logic last);
    timer_result_t r;
    r.st = st; r.id = id; r.tl = tl; r.last = last;
    pending_results.push_back(r);
  endtask

  // advance the shadow store by one accepted item
  task automatic predict_item(logic [ACT_W-1:0] act, logic [DELAY_W-1:0] delay, logic vm,
                              logic [TID_W-1:0] tid, logic [DELAY_W-1:0] rv);
    int s, p, n;
    timer_result_t r;
    case (act)
      ACT_ADD: begin
        s = -1;
        for (int i = DEPTH - 1; i >= 0; i--) if (!in_use[i]) s = i;
        if (s < 0) expect_result(ST_FULL, '0, '0, 1'b1);
        else begin
          ev_id[s] = next_id;
          next_id++;
          due_at[s] = now_ms + delay;
          period[s] = delay;
          var_mode[s] = vm;
          in_use[s] = 1'b1;
          fired[s] = 1'b0;
          enqueue(s);
          expect_result(ST_OK, ev_id[s], '0, 1'b1);
        end
      end
      ACT_DEL: begin
        p = find_queued(tid);
        if (p < 0) expect_result(ST_NOT_FOUND, tid, '0, 1'b1);
        else begin
          s = due_list[p];
          dequeue(p);
          in_use[s] = 1'b0;
          expect_result(ST_OK, ev_id[s], '0, 1'b1);
        end
      end
      ACT_TICK: begin
        now_ms++;
        n = 0;
        while (due_len > 0 && n < MAX_RESULTS && is_due(due_list[0])) begin
          s = due_list[0];
          dequeue(0);
          fired[s] = 1'b1;
          expect_result(ST_FIRED, ev_id[s], '0, 1'b0);
          n++;
        end
        if (n == 0) expect_result(ST_OK, '0, '0, 1'b1);
        else begin
          r = pending_results.pop_back();
          r.last = 1'b1;
          pending_results.push_back(r);
        end
      end
      ACT_REARM: begin
        s = -1;
        for (int i = DEPTH - 1; i >= 0; i--)
          if (in_use[i] && fired[i] && ev_id[i] == tid) s = i;
        if (s < 0) expect_result(ST_NOT_FOUND, tid, '0, 1'b1);
        else begin
          fired[s] = 1'b0;
          if (rv == 0) in_use[s] = 1'b0;
          else begin
            due_at[s] = due_at[s] + (var_mode[s] ? rv : period[s]);
            enqueue(s);
          end
          expect_result(ST_OK, ev_id[s], '0, 1'b1);
        end
      end
      ACT_QID: begin
        p = find_queued(tid);
        if (p < 0) expect_result(ST_NOT_FOUND, tid, '1, 1'b1);
        else expect_result(ST_OK, ev_id[due_list[p]], time_left(due_list[p]), 1'b1);
      end
      ACT_QNEXT: begin
        if (due_len == 0) expect_result(ST_OK, '0, '1, 1'b1);
        else expect_result(ST_OK, '0, time_left(due_list[0]), 1'b1);
      end
      default: expect_result(ST_OK, '0, '0, 1'b1);
    endcase
  endtask

  always @(posedge clk) begin
    timer_result_t want;
    if (!rst_n) begin
      now_ms = '0;
      next_id = 1;
      due_len = 0;
      for (int i = 0; i < DEPTH; i++) begin
        in_use[i] = 1'b0;
        fired[i] = 1'b0;
      end
      pending_results.delete();
      fail_count = 0;
      checked = 0;
      fired_seen = 0;
    end else begin
      // results first: a result never belongs to the item taken at the same edge
      if (out_tvalid && out_tready) begin
        checked++;
        if (out_tuser == ST_FIRED) fired_seen++;
        if (pending_results.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result: actual status %0d id %0d tl %0d last %0b",
                   $realtime, out_tuser, out_tdata[15:0], $signed(out_tdata[40:16]),
                   out_tlast);
        end else begin
          want = pending_results.pop_front();
          if (out_tuser !== want.st || out_tdata[15:0] !== want.id ||
              out_tdata[40:16] !== want.tl || out_tlast !== want.last ||
              out_tdata[OUT_TDATA_W-1:41] !== '0) begin
            fail_count++;
            $display("%0t: mismatch: expected status %0d id %0d tl %0d last %0b",
                     $realtime, want.st, want.id, $signed(want.tl), want.last);
            $display("%0t:           actual status %0d id %0d tl %0d last %0b",
                     $realtime, out_tuser, out_tdata[15:0], $signed(out_tdata[40:16]),
                     out_tlast);
          end
        end
      end
      if (in_tvalid && in_tready)
        predict_item(in_tuser, in_tdata[23:0], in_tdata[24], in_tdata[40:25],
                     in_tdata[64:41]);
    end
  end

endmodule

// ===== tb/sorted_event_timer_queue_core_tb.sv =====
// Top of the testbench for the sorted event timer queue: clock, reset, stimulus, verdict.
// Depends on sevq_pkg, sorted_event_timer_queue_core and sorted_event_timer_queue_core_chk.
`timescale 1ns / 100ps

module sorted_event_timer_queue_core_tb;
  import sevq_pkg::*;

  // codes the block treats as no-ops
  localparam logic [ACT_W-1:0] ACT_SPARE_6 = 3'd6;
  localparam logic [ACT_W-1:0] ACT_SPARE_7 = 3'd7;
  localparam int RANDOM_ITEMS = 421;
  localparam int WATCHDOG_LIMIT = 20000;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [ACT_W-1:0]       in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [1:0]             out_tuser;
  logic                   out_tlast;
  int fail_count, awaiting, checked, fired_seen;
  int adds_sent;
  bit quiet;
  int idle_cycles;

  sorted_event_timer_queue_core dut (.*);
  sorted_event_timer_queue_core_chk chk (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // result side stall, off during the quiet stretch
  always @(negedge clk) out_tready <= quiet || ($urandom_range(99) >= 22);

  // watchdog: cycles with no item moving on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("sorted_event_timer_queue_core_tb failed");
      $finish;
    end
  end

  // called at a falling edge; ready is checked there, away from the rising edge
  task automatic send_item(logic [ACT_W-1:0] act, logic [DELAY_W-1:0] delay, logic vm,
                           logic [TID_W-1:0] tid, logic [DELAY_W-1:0] rv);
    while (!quiet && $urandom_range(99) < 22) @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser = act;
    in_tdata = {7'd0, rv, tid, vm, delay};
    while (!in_tready) @(negedge clk);
    @(posedge clk);
    if (act == ACT_ADD) adds_sent++;
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  function automatic logic [TID_W-1:0] pick_id();
    if ($urandom_range(9) == 0) return TID_W'($urandom_range(16'hFFFF));
    return TID_W'($urandom_range(adds_sent + 1));
  endfunction

  task automatic random_item();
    int w;
    logic [DELAY_W-1:0] d, rv;
    logic vm;
    w = $urandom_range(99);
    vm = 1'($urandom_range(1));
    d = ($urandom_range(7) == 0) ? DELAY_W'($urandom_range(24'hFFFFFF)) :
                                   DELAY_W'($urandom_range(12));
    rv = ($urandom_range(5) == 0) ? 24'd0 :
         ($urandom_range(7) == 0) ? DELAY_W'($urandom_range(24'hFFFFFF)) :
                                    DELAY_W'($urandom_range(10));
    if (w < 25)      send_item(ACT_ADD, d, vm, pick_id(), rv);
    else if (w < 55) send_item(ACT_TICK, d, vm, pick_id(), rv);
    else if (w < 72) send_item(ACT_REARM, d, vm, pick_id(), rv);
    else if (w < 82) send_item(ACT_DEL, d, vm, pick_id(), rv);
    else if (w < 91) send_item(ACT_QID, d, vm, pick_id(), rv);
    else if (w < 97) send_item(ACT_QNEXT, d, vm, pick_id(), rv);
    else send_item($urandom_range(1) ? ACT_SPARE_6 : ACT_SPARE_7, d, vm,
                   pick_id(), rv);
  endtask

  initial begin
    int waited;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    quiet = 1'b0;
    adds_sent = 0;
    idle_cycles = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: empty queries, extremes, fire and rearm, full store, burst of due events
    send_item(ACT_QNEXT, '0, 1'b0, '0, '0);                    // empty queue
    send_item(ACT_ADD, 24'd0, 1'b0, '1, '1);                   // id 1, due at once
    send_item(ACT_ADD, 24'hFFFFFF, 1'b1, '0, '0);              // id 2, longest delay
    send_item(ACT_QID, '0, 1'b0, 16'd2, '0);
    send_item(ACT_QID, '0, 1'b0, 16'hFFFF, '0);                // absent id
    send_item(ACT_QNEXT, '0, 1'b0, '0, '0);
    send_item(ACT_DEL, '0, 1'b0, 16'hFFFF, '0);                // absent id
    send_item(ACT_SPARE_6, '1, 1'b1, '1, '1);
    send_item(ACT_SPARE_7, '0, 1'b0, '0, '0);
    send_item(ACT_TICK, '0, 1'b0, '0, '0);                     // fires id 1
    send_item(ACT_DEL, '0, 1'b0, 16'd1, '0);                   // fired, not queued
    send_item(ACT_REARM, '0, 1'b0, 16'd1, 24'd3);              // late rearm by period 0
    send_item(ACT_TICK, '0, 1'b0, '0, '0);                     // fires id 1 again
    send_item(ACT_REARM, '0, 1'b0, 16'd1, 24'd0);              // release
    send_item(ACT_REARM, '0, 1'b0, 16'd1, 24'd5);              // no longer pending
    send_item(ACT_TICK, '0, 1'b0, '0, '0);                     // quiet tick
    for (int i = 0; i < 15; i++) send_item(ACT_ADD, 24'd1, i[0], '0, '0);
    send_item(ACT_ADD, 24'd1, 1'b0, '0, '0);                   // store full
    send_item(ACT_DEL, '0, 1'b0, 16'd2, '0);
    send_item(ACT_TICK, '0, 1'b0, '0, '0);                     // fires fifteen in order
    for (int i = 3; i < 18; i++) send_item(ACT_REARM, '0, 1'b0, i[15:0], 24'(i & 3));

    // random part with one long stretch without idling on either side
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      quiet = (k >= 150 && k < 230);
      random_item();
    end
    quiet = 1'b0;

    waited = 0;
    while (awaiting != 0 && waited < WATCHDOG_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (60) @(posedge clk);
    $display("Covered %0d adds and %0d results checked, %0d of them fired events.",
             adds_sent, checked, fired_seen);
    $display("Mismatches: %0d, results still owed: %0d.", fail_count, awaiting);
    if (fail_count == 0 && awaiting == 0) $display("sorted_event_timer_queue_core_tb passed");
    else $display("sorted_event_timer_queue_core_tb failed");
    $finish;
  end

endmodule
